### hw/rtl/block_pool_allocator_defines.svh
// Assertion helpers shared by the allocator RTL.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define BPA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("block pool allocator: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define BPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("block pool allocator: next-cycle check failed");

`endif

### hw/rtl/bpa_pkg.sv
package bpa_pkg;

  // Pool geometry
  localparam int TOTAL_BLOCK_COUNT = 128;
  localparam int BLOCKS_IN_BANK    = 64;
  localparam int BLOCK_BYTES       = 1024;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int BLK_W    = 8;
  localparam int ADDR_W   = 28;
  localparam int STATUS_W = 2;
  localparam int IDX_W    = (TOTAL_BLOCK_COUNT > 1) ? $clog2(TOTAL_BLOCK_COUNT) : 1;
  localparam int BYTES_W  = 17;
  localparam int PROD_W   = BLK_W + BYTES_W;

  // Stream packing
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = ((BLK_W + ADDR_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - BLK_W - ADDR_W;

  // Configuration port
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BANK0 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BANK1 = 1'd1;
  localparam logic [ADDR_W-1:0] BANK0_RESET = 28'h0040000;
  localparam logic [ADDR_W-1:0] BANK1_RESET = 28'h0050000;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RETRIEVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_STORE    = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNALLOC = 2'd3;

  // Access to the used-flag store: one write and one registered read per cycle
  typedef struct packed {
    logic             set;
    logic             clr;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
  } flag_op_t;

  // Address unit request and response
  typedef struct packed {
    logic             start;
    logic [BLK_W-1:0] idx;
  } addr_req_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] addr;
  } addr_rsp_t;

endpackage

### hw/rtl/bpa_flags.sv
module bpa_flags
  import bpa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  flag_op_t op_i,
  output logic     used_o
);

  logic [TOTAL_BLOCK_COUNT-1:0] flags_q;
  logic                         used_q;

  // One used flag per block, all free after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (op_i.set) begin
      flags_q[op_i.wr_idx] <= 1'b1;
    end else if (op_i.clr) begin
      flags_q[op_i.wr_idx] <= 1'b0;
    end
  end

  // Registered read: the flag shows up the cycle after its index
  always_ff @(posedge clk_i) begin
    used_q <= flags_q[op_i.rd_idx];
  end

  assign used_o = used_q;

endmodule

### hw/rtl/bpa_addr.sv
module bpa_addr
  import bpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  addr_req_t         req_i,
  input  logic [ADDR_W-1:0] bank0_base_i,
  input  logic [ADDR_W-1:0] bank1_base_i,
  output addr_rsp_t         rsp_o
);

  localparam logic [1:0] A_IDLE   = 2'd0;
  localparam logic [1:0] A_REDUCE = 2'd1;
  localparam logic [1:0] A_MUL    = 2'd2;
  localparam logic [1:0] A_ADD    = 2'd3;

  localparam logic [BLK_W-1:0]  PER   = BLK_W'(BLOCKS_IN_BANK);
  localparam logic [PROD_W-1:0] BYTES = PROD_W'(BLOCK_BYTES);

  logic [1:0]        st_q, st_d;
  logic [BLK_W-1:0]  rem_q, rem_d;
  logic              hi_q, hi_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              done_q, done_d;
  logic [ADDR_W-1:0] base;

  // Second bank for any index at or past one bank (saturates)
  assign base = hi_q ? bank1_base_i : bank0_base_i;

  // Sequencer: reduce index by bank size, scale slot, add base
  always_comb begin
    st_d   = st_q;
    rem_d  = rem_q;
    hi_d   = hi_q;
    prod_d = prod_q;
    addr_d = addr_q;
    done_d = 1'b0;
    unique case (st_q)
      A_IDLE: begin
        if (req_i.start) begin
          rem_d = req_i.idx;
          hi_d  = 1'b0;
          st_d  = A_REDUCE;
        end
      end
      A_REDUCE: begin
        if (rem_q >= PER) begin
          rem_d = rem_q - PER;
          hi_d  = 1'b1;
        end else begin
          st_d = A_MUL;
        end
      end
      A_MUL: begin
        prod_d = PROD_W'(rem_q) * BYTES;
        st_d   = A_ADD;
      end
      A_ADD: begin
        addr_d = base + ADDR_W'(prod_q);
        done_d = 1'b1;
        st_d   = A_IDLE;
      end
      default: st_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= A_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    hi_q   <= hi_d;
    prod_q <= prod_d;
    addr_q <= addr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.addr = addr_q;

endmodule

### hw/rtl/block_pool_allocator.sv
// Block pool allocator: keeps one used flag per block of a fixed pool and serves one
// request at a time on a stream port; the result waits in an output register. Free and
// every range or not-allocated error go from the check state to the finish state.
// Allocate walks the flags one per cycle from the lowest block and stops at the first
// free block, or at the last block with a pool-full status when all are in use.
// Retrieve and store run the address unit: one subtract per whole bank below the block
// (index / BLOCKS_IN_BANK steps), then one multiply and one add; a block in the first
// bank of 64 needs no subtract. A new request can be taken in the cycle after the
// result register is loaded; a result that is not taken holds the next one back.
// Users must write the bank base registers only while idle; it is not enforced.
`include "block_pool_allocator_defines.svh"

module block_pool_allocator
  import bpa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Request stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // [7:0] block_number
  input  logic [CMD_W-1:0]      s_axis_tuser_i,  // [1:0] cmd
  // Result stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,  // [7:0] given_block, [35:8] bank_address
  output logic [STATUS_W-1:0]   m_axis_tuser_o,  // [1:0] status
  // Configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ADDR_W-1:0]     cfg_wdata_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_ADDR   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TOTAL_BLOCK_COUNT - 1);
  localparam logic [BLK_W-1:0] TOTAL    = BLK_W'(TOTAL_BLOCK_COUNT);

  logic [2:0]          state_q, state_d;
  logic [CMD_W-1:0]    cmd_q;
  logic [BLK_W-1:0]    num_q;
  logic [IDX_W-1:0]    ptr_q, ptr_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [BLK_W-1:0]    res_given_q, res_given_d;
  logic [ADDR_W-1:0]   res_addr_q, res_addr_d;
  logic                m_valid_q;
  logic [STATUS_W-1:0] m_user_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic [ADDR_W-1:0]   bank0_q, bank1_q;

  logic       in_acc;
  logic       out_load;
  logic       range_bad;
  logic [BLK_W-1:0] num_m1;
  logic [IDX_W-1:0] in_m1;
  logic       used;
  flag_op_t   flag_op;
  addr_req_t  addr_req;
  addr_rsp_t  addr_rsp;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign num_m1          = num_q - BLK_W'(1);
  assign in_m1           = s_axis_tdata_i[IDX_W-1:0] - IDX_W'(1);
  assign range_bad       = (num_q == '0) || (num_q > TOTAL);
  assign out_load        = (state_q == S_FINISH) && (!m_valid_q || m_axis_tready_i);

  // Bank base registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank0_q <= BANK0_RESET;
      bank1_q <= BANK1_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BANK0: bank0_q <= cfg_wdata_i;
        REG_BANK1: bank1_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Flag store: write at the scan pointer or the requested block; the registered
  // read fetches the incoming block while idle, else the next scan position
  always_comb begin
    flag_op.wr_idx = (state_q == S_SCAN) ? ptr_q : num_m1[IDX_W-1:0];
    flag_op.rd_idx = (state_q == S_IDLE) ? in_m1 : ptr_d;
    flag_op.set    = (state_q == S_SCAN) && !used;
    flag_op.clr    = (state_q == S_CHECK) && (cmd_q == CMD_FREE) && !range_bad;
  end

  bpa_flags u_flags (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (flag_op),
    .used_o (used)
  );

  // Address unit starts on a valid retrieve or store of an allocated block
  assign addr_req.start = (state_q == S_CHECK) && !range_bad && used &&
                          ((cmd_q == CMD_RETRIEVE) || (cmd_q == CMD_STORE));
  assign addr_req.idx   = num_m1;

  bpa_addr u_addr (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (addr_req),
    .bank0_base_i (bank0_q),
    .bank1_base_i (bank1_q),
    .rsp_o        (addr_rsp)
  );

  // Request sequencer
  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    res_status_d = res_status_q;
    res_given_d  = res_given_q;
    res_addr_d   = res_addr_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        res_status_d = ST_OK;
        res_given_d  = '0;
        res_addr_d   = '0;
        ptr_d        = '0;
        if (cmd_q == CMD_ALLOC) begin
          state_d = S_SCAN;
        end else if (range_bad) begin
          res_status_d = ST_RANGE;
          state_d      = S_FINISH;
        end else if (cmd_q == CMD_FREE) begin
          state_d = S_FINISH;
        end else if (!used) begin
          res_status_d = ST_UNALLOC;
          state_d      = S_FINISH;
        end else begin
          state_d = S_ADDR;
        end
      end
      S_SCAN: begin
        if (!used) begin
          res_given_d = BLK_W'(ptr_q) + BLK_W'(1);
          state_d     = S_FINISH;
        end else if (ptr_q == LAST_IDX) begin
          res_status_d = ST_NOSPACE;
          state_d      = S_FINISH;
        end else begin
          ptr_d = ptr_q + IDX_W'(1);
        end
      end
      S_ADDR: begin
        if (addr_rsp.done) begin
          res_addr_d = addr_rsp.addr;
          state_d    = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= s_axis_tuser_i;
      num_q <= s_axis_tdata_i[BLK_W-1:0];
    end
    ptr_q        <= ptr_d;
    res_status_q <= res_status_d;
    res_given_q  <= res_given_d;
    res_addr_q   <= res_addr_d;
    if (out_load) begin
      m_user_q <= res_status_q;
      m_data_q <= {{OUT_PAD_W{1'b0}}, res_addr_q, res_given_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tdata_o  = m_data_q;

  // Checks
  `BPA_ASSERT_NEXT(a_busy_after_req, in_acc, !s_axis_tready_o)
  `BPA_ASSERT_NOW(a_error_zero_data, m_axis_tvalid_o && (m_axis_tuser_o != ST_OK),
                  m_axis_tdata_o == '0)
  `BPA_ASSERT_NOW(a_grant_no_addr, m_axis_tvalid_o && (m_axis_tdata_o[BLK_W-1:0] != '0),
                  (m_axis_tdata_o[BLK_W+ADDR_W-1:BLK_W] == '0) && (m_axis_tuser_o == ST_OK))

endmodule

### tb/tb_block_pool_allocator.sv
`timescale 1ns / 100ps

module tb_block_pool_allocator
  import bpa_pkg::*;
();

  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int LONG_HOLD       = 300;
  localparam int DRAIN_CYCLES    = TOTAL_BLOCK_COUNT + 24;
  localparam int DIR_ROWS        = 26;
  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
  // share of allocate requests per random phase, in percent
  localparam int ALLOC_PCT [PHASES] = '{55, 30, 70, 40, 25, 50};

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLK_W-1:0]    given;
    logic [ADDR_W-1:0]   addr;
  } alloc_resp_t;

  // one directed request, repeated reps times; resp holds only when typed is set
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [BLK_W-1:0] blk;
    logic [7:0]       reps;
    logic             typed;
    alloc_resp_t      resp;
  } dir_row_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;  // [7:0] block_number
  logic [CMD_W-1:0]      s_axis_tuser_i  = '0;  // [1:0] cmd
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;        // [7:0] given_block, [35:8] bank_address
  logic [STATUS_W-1:0]   m_axis_tuser_o;        // [1:0] status
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i       = '0;
  logic [ADDR_W-1:0]     cfg_wdata_i     = '0;

  // Allocator image: used flags, bank bases, responses still owed
  bit                pool_used [1:TOTAL_BLOCK_COUNT];
  logic [ADDR_W-1:0] bank_base [2];
  alloc_resp_t       pending_resp [$];

  int  sent_cnt      = 0;
  int  checked_cnt   = 0;
  int  err_cnt       = 0;
  int  cycle_cnt     = 0;
  int  settings_cnt  = 1;
  int  status_seen [4];
  bit  quiet         = 1'b0;
  bit  long_hold_go  = 1'b0;

  // Directed requests, under the reset bank bases
  dir_row_t dir_table [DIR_ROWS] = '{
    '{CMD_RETRIEVE, 8'd1,   8'd1,   1'b1, '{ST_UNALLOC, 8'd0,   28'h0}},
    '{CMD_STORE,    8'd0,   8'd1,   1'b1, '{ST_RANGE,   8'd0,   28'h0}},
    '{CMD_FREE,     8'd0,   8'd1,   1'b1, '{ST_RANGE,   8'd0,   28'h0}},
    '{CMD_FREE,     8'd129, 8'd1,   1'b1, '{ST_RANGE,   8'd0,   28'h0}},
    '{CMD_RETRIEVE, 8'd255, 8'd1,   1'b1, '{ST_RANGE,   8'd0,   28'h0}},
    '{CMD_FREE,     8'd5,   8'd1,   1'b1, '{ST_OK,      8'd0,   28'h0}},
    '{CMD_ALLOC,    8'd255, 8'd1,   1'b1, '{ST_OK,      8'd1,   28'h0}},
    '{CMD_ALLOC,    8'd0,   8'd1,   1'b1, '{ST_OK,      8'd2,   28'h0}},
    '{CMD_RETRIEVE, 8'd1,   8'd1,   1'b1, '{ST_OK,      8'd0,   28'h0040000}},
    '{CMD_STORE,    8'd2,   8'd1,   1'b1, '{ST_OK,      8'd0,   28'h0040400}},
    '{CMD_STORE,    8'd128, 8'd1,   1'b1, '{ST_UNALLOC, 8'd0,   28'h0}},
    '{CMD_FREE,     8'd1,   8'd1,   1'b1, '{ST_OK,      8'd0,   28'h0}},
    '{CMD_ALLOC,    8'd128, 8'd1,   1'b1, '{ST_OK,      8'd1,   28'h0}},
    '{CMD_ALLOC,    8'd85,  8'd126, 1'b0, '{ST_OK,      8'd0,   28'h0}},
    '{CMD_ALLOC,    8'd170, 8'd1,   1'b1, '{ST_NOSPACE, 8'd0,   28'h0}},
    '{CMD_RETRIEVE, 8'd128, 8'd1,   1'b1, '{ST_OK,      8'd0,   28'h005FC00}},
    '{CMD_STORE,    8'd65,  8'd1,   1'b1, '{ST_OK,      8'd0,   28'h0050000}},
    '{CMD_RETRIEVE, 8'd64,  8'd1,   1'b1, '{ST_OK,      8'd0,   28'h004FC00}},
    '{CMD_FREE,     8'd128, 8'd1,   1'b1, '{ST_OK,      8'd0,   28'h0}},
    '{CMD_STORE,    8'd128, 8'd1,   1'b1, '{ST_UNALLOC, 8'd0,   28'h0}},
    '{CMD_FREE,     8'd70,  8'd1,   1'b1, '{ST_OK,      8'd0,   28'h0}},
    '{CMD_FREE,     8'd3,   8'd1,   1'b1, '{ST_OK,      8'd0,   28'h0}},
    '{CMD_ALLOC,    8'd0,   8'd1,   1'b1, '{ST_OK,      8'd3,   28'h0}},
    '{CMD_ALLOC,    8'd0,   8'd1,   1'b1, '{ST_OK,      8'd70,  28'h0}},
    '{CMD_ALLOC,    8'd0,   8'd1,   1'b1, '{ST_OK,      8'd128, 28'h0}},
    '{CMD_ALLOC,    8'd0,   8'd1,   1'b1, '{ST_NOSPACE, 8'd0,   28'h0}}
  };

  block_pool_allocator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Expected response of one accepted request; updates the used flags
  function automatic alloc_resp_t predict_alloc(input logic [CMD_W-1:0] cmd,
                                                input logic [BLK_W-1:0] blk);
    alloc_resp_t r;
    int          idx;
    int          slot;
    longint      sum;
    bit          found;
    r = '0;
    r.status = ST_OK;
    found = 1'b0;
    if (cmd == CMD_ALLOC) begin
      // first fit, lowest number first
      r.status = ST_NOSPACE;
      for (int i = 1; i <= TOTAL_BLOCK_COUNT; i++) begin
        if (!found && !pool_used[i]) begin
          pool_used[i] = 1'b1;
          r.given = i[BLK_W-1:0];
          r.status = ST_OK;
          found = 1'b1;
        end
      end
    end else if (blk == 0 || int'(blk) > TOTAL_BLOCK_COUNT) begin
      r.status = ST_RANGE;
    end else if (cmd == CMD_FREE) begin
      pool_used[blk] = 1'b0;
    end else if (!pool_used[blk]) begin
      r.status = ST_UNALLOC;
    end else begin
      // bank base (saturating at the second bank) plus slot offset, 28-bit wrap
      idx  = int'(blk) - 1;
      slot = idx % BLOCKS_IN_BANK;
      sum  = longint'(bank_base[(idx / BLOCKS_IN_BANK) == 0 ? 0 : 1])
           + longint'(slot) * longint'(BLOCK_BYTES);
      r.addr = sum[ADDR_W-1:0];
    end
    return r;
  endfunction

  // Mostly an allocated block, so retrieve/store/free get past the checks
  function automatic logic [BLK_W-1:0] busy_block();
    int start;
    int n;
    start = $urandom_range(1, TOTAL_BLOCK_COUNT);
    if ($urandom_range(0, 7) == 0) return BLK_W'(start);
    for (int k = 0; k < TOTAL_BLOCK_COUNT; k++) begin
      n = (start - 1 + k) % TOTAL_BLOCK_COUNT + 1;
      if (pool_used[n]) return BLK_W'(n);
    end
    return BLK_W'(start);
  endfunction

  // Offer one request, optionally after an idle burst; valid stays high on return
  task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [BLK_W-1:0] blk,
                          input logic typed, input alloc_resp_t typed_resp);
    alloc_resp_t r;
    int          gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= blk;
    s_axis_tuser_i  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    r = predict_alloc(cmd, blk);
    if (typed) r = typed_resp;
    pending_resp.push_back(r);
    status_seen[r.status]++;
    sent_cnt++;
  endtask

  // Stop offering and wait until the block has answered everything
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write both bank bases back to back; only called while idle
  task automatic program_banks(input logic [ADDR_W-1:0] b0, input logic [ADDR_W-1:0] b1);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_BANK0;
    cfg_wdata_i <= b0;
    @(posedge clk_i);
    cfg_idx_i   <= REG_BANK1;
    cfg_wdata_i <= b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    bank_base[0] = b0;
    bank_base[1] = b1;
    settings_cnt++;
  endtask

  // Compare one accepted response with the oldest one owed
  task automatic check_resp();
    alloc_resp_t got;
    alloc_resp_t want;
    got.status = m_axis_tuser_o;
    got.given  = m_axis_tdata_o[BLK_W-1:0];
    got.addr   = m_axis_tdata_o[BLK_W +: ADDR_W];
    checked_cnt++;
    if (pending_resp.size() == 0) begin
      err_cnt++;
      if (err_cnt <= 10)
        $display("unexpected response: status %0d block %0d addr %h",
                 got.status, got.given, got.addr);
    end else begin
      want = pending_resp.pop_front();
      if (got !== want) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("mismatch %0d (exp/got): status %0d/%0d block %0d/%0d addr %h/%h",
                   checked_cnt, want.status, got.status, want.given, got.given,
                   want.addr, got.addr);
      end
    end
  endtask

  // Response side: check, then pick next tready (bursts, one long hold)
  initial begin : result_sink
    int stall_left;
    bit long_hold_done;
    stall_left = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) check_resp();
      if (long_hold_go && !long_hold_done) begin
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Timeout
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d responses owed", cycle_cnt, pending_resp.size());
    $display("tb_block_pool_allocator: done, errors");
    $finish;
  end

  // Request side
  initial begin : stimulus
    logic [CMD_W-1:0] cmd;
    logic [BLK_W-1:0] blk;
    int               pick;
    int               alloc_pct;
    bank_base[0] = BANK0_RESET;
    bank_base[1] = BANK1_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table under reset bank bases
    foreach (dir_table[i])
      for (int k = 0; k < int'(dir_table[i].reps); k++)
        send_req(dir_table[i].cmd, dir_table[i].blk, dir_table[i].typed, dir_table[i].resp);
    settle();

    // random phases, each under its own bank setting
    for (int p = 0; p < PHASES; p++) begin
      unique case (p)
        0: program_banks('0, ADDR_MAX);
        1: program_banks(ADDR_MAX, '0);
        2: program_banks(ADDR_MAX - ADDR_W'($urandom_range(0, 'h1FFFF)),
                         ADDR_MAX - ADDR_W'($urandom_range(0, 'h1FFFF)));
        3: program_banks(BANK1_RESET, BANK0_RESET);
        default: program_banks(ADDR_W'($urandom()), ADDR_W'($urandom()));
      endcase
      quiet = (p == PHASES - 1);
      alloc_pct = ALLOC_PCT[p];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // once: receiver holds off while requests keep coming
        if (p == 1 && n == 40) long_hold_go = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < alloc_pct) begin
          cmd = CMD_ALLOC;
          blk = BLK_W'($urandom_range(0, 255));
        end else if (pick < alloc_pct + 10) begin
          cmd = CMD_W'($urandom_range(0, 3));
          blk = BLK_W'($urandom_range(0, 255));
        end else begin
          if ($urandom_range(0, 1) == 0) cmd = CMD_FREE;
          else if ($urandom_range(0, 1) == 0) cmd = CMD_RETRIEVE;
          else cmd = CMD_STORE;
          blk = busy_block();
        end
        send_req(cmd, blk, 1'b0, '0);
      end
      settle();
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pending_resp.size() != 0) begin
      err_cnt += pending_resp.size();
      $display("%0d responses never arrived", pending_resp.size());
    end
    $display("%0d requests, %0d responses checked under %0d bank settings, %0d errors",
             sent_cnt, checked_cnt, settings_cnt, err_cnt);
    $display("statuses seen: ok %0d, pool full %0d, out of range %0d, not allocated %0d",
             status_seen[ST_OK], status_seen[ST_NOSPACE], status_seen[ST_RANGE],
             status_seen[ST_UNALLOC]);
    if (err_cnt == 0) begin
      $display("tb_block_pool_allocator: done, clean");
    end else begin
      $display("tb_block_pool_allocator: done, errors");
    end
    $finish;
  end

endmodule
